// File: design/bsa_pkg.sv
// shared types, sizes and codes for the bitmap slot allocator
package bsa_pkg;

  localparam int NUM_BLOCKS      = 4;
  localparam int SLOTS_PER_BLOCK = 64;
  localparam int BIT_W           = 6;
  localparam int GRP_W           = 3;
  localparam int GRP_SIZE        = 8;
  localparam int NUM_GRPS        = SLOTS_PER_BLOCK / GRP_SIZE;
  localparam int BLK_W           = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int NUM_SLOTS       = NUM_BLOCKS * SLOTS_PER_BLOCK;
  localparam int SLOT_W          = BLK_W + BIT_W;
  localparam int CNT_W           = $clog2(NUM_SLOTS + 1);

  localparam int ESZ_W    = 13;
  localparam int OFF_W    = 20;
  localparam int ST_W     = 3;
  localparam int USED_W   = 9;
  localparam int USED_SAT = 511;
  localparam int PROD_W   = SLOT_W + ESZ_W;
  localparam int CMP_W    = (PROD_W > OFF_W) ? PROD_W : OFF_W;

  localparam logic [ESZ_W-1:0] ESZ_RESET  = ESZ_W'(16);
  localparam logic [ESZ_W-1:0] ESZ_MIN    = ESZ_W'(1);
  localparam logic [ESZ_W-1:0] ESZ_MAX    = ESZ_W'(4096);
  localparam logic [OFF_W-1:0] OFFSET_MAX = '1;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ELEMENT_SIZE = 1'b0;

  // stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;
  localparam int M_PAD_W   = M_TDATA_W - OFF_W - USED_W;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_ALIGN  = 3'd3,
    ST_UNUSED = 3'd4
  } status_t;

  localparam int DIV_CNT_W = $clog2(OFF_W + 1);

  typedef struct packed {
    logic             start;
    logic [OFF_W-1:0] dividend;
    logic [ESZ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] quot;
    logic [ESZ_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: design/bitmap_slot_allocator_unit.sv
// bitmap slot allocator: top level with request sequencer, mask memory and config register
//
//  channel   dir  payload                                          transfer when
//  s_*       in   tuser: func; tdata: byte_offset                  s_tvalid & s_tready
//  m_*       out  tuser: status; tdata: slot_offset, used_count    m_tvalid & m_tready
//  apb       in   element_size at byte address 0                   psel & penable & pwrite
//
// allocate: block masks are read in turn until one has a free slot, then group pick, bit pick,
//   offset multiply, fit check and commit; when every block is full, a full status is committed
// free: the range check is made on the request transfer; in range, the 20-step divider runs,
//   and an aligned offset goes on to the block read and bit test before commit; a misaligned
//   one, or one out of range, goes straight to commit
// one request is in flight at a time; the result waits in the output register and the next
//   request is taken while it waits, but is only committed once that result has gone
// reset is synchronous; masks are cleared by per-block valid bits, no clearing pass
// the mask write-back lands before the next read, with the idle state between them, so no forwarding
module bitmap_slot_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bsa_pkg::S_TDATA_W-1:0]   s_tdata,   // [19:0] byte_offset, [23:20] zero
  input  logic                            s_tuser,   // [0] func
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bsa_pkg::M_TDATA_W-1:0]   m_tdata,   // [19:0] slot_offset, [28:20] used_count
  output logic [bsa_pkg::ST_W-1:0]        m_tuser,   // [2:0] status
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsa_pkg::APB_AW-1:0]      paddr,
  input  logic [bsa_pkg::APB_DW-1:0]      pwdata,
  output logic [bsa_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a request
    S_RD,     // issue mask read for block k
    S_CHK,    // mask data back: scan or test the bit
    S_GRP,    // pick first byte group with a zero
    S_BIT,    // pick first zero bit in that group
    S_MUL,    // slot times element size
    S_ALLOC,  // offset fits check
    S_DIV,    // offset divided by element size
    S_FIN     // commit and hand over the result
  } state_t;

  state_t state;

  // configuration register
  logic [bsa_pkg::ESZ_W-1:0] esz;
  logic [bsa_pkg::ESZ_W-1:0] cfg_val;
  logic                      cfg_wr;

  // request context
  logic                        func_q;
  logic [bsa_pkg::BLK_W-1:0]   k_q;
  logic [bsa_pkg::BIT_W-1:0]   bit_q;
  logic [bsa_pkg::GRP_W-1:0]   grp_q;
  logic [bsa_pkg::NUM_GRPS-1:0] gz_q;
  logic [bsa_pkg::SLOTS_PER_BLOCK-1:0] mask_q;
  logic [bsa_pkg::PROD_W-1:0]  prod_q;
  logic                        do_write_q;
  logic                        inc_q;
  logic                        rd_valid_q;
  bsa_pkg::status_t            st_q;
  logic [bsa_pkg::OFF_W-1:0]   res_off_q;

  // persistent state outside the ram
  logic [bsa_pkg::NUM_BLOCKS-1:0] blk_valid;
  logic [bsa_pkg::CNT_W-1:0]      cnt;
  logic [bsa_pkg::CNT_W-1:0]      cnt_new;

  // output register
  bsa_pkg::status_t            out_st;
  logic [bsa_pkg::OFF_W-1:0]   out_off;
  logic [bsa_pkg::USED_W-1:0]  out_used;

  // memory port
  logic                                 ram_we;
  logic                                 ram_re;
  logic [bsa_pkg::SLOTS_PER_BLOCK-1:0]  ram_rdata;
  logic [bsa_pkg::SLOTS_PER_BLOCK-1:0]  mask_rd;

  bsa_pkg::div_req_t div_req;
  bsa_pkg::div_rsp_t div_rsp;

  logic                          accept;
  logic                          fin_go;
  logic                          in_func;
  logic [bsa_pkg::OFF_W-1:0]     in_off;
  logic [bsa_pkg::CMP_W-1:0]     limit;
  logic                          out_of_range;
  logic [bsa_pkg::GRP_W-1:0]     grp_pick;
  logic [bsa_pkg::GRP_W-1:0]     bit_pick;
  logic [bsa_pkg::GRP_SIZE-1:0]  grp_byte;
  logic [bsa_pkg::SLOT_W-1:0]    slot;

  assign in_func = s_tuser;
  assign in_off  = s_tdata[bsa_pkg::OFF_W-1:0];

  // nothing is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign fin_go   = (state == S_FIN) && (!m_tvalid || m_tready);

  // range limit is element size times slot count: a constant multiply
  assign limit        = bsa_pkg::CMP_W'(esz) * bsa_pkg::CMP_W'(bsa_pkg::NUM_SLOTS);
  assign out_of_range = (bsa_pkg::CMP_W'(in_off) >= limit);

  // divider kicked off straight from the accepted request
  assign div_req.start    = accept && (in_func == bsa_pkg::FN_FREE) && !out_of_range;
  assign div_req.dividend = in_off;
  assign div_req.divisor  = esz;

  bsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // masks of blocks never written read as all free
  assign mask_rd = rd_valid_q ? ram_rdata : '0;
  assign ram_re  = (state == S_RD);
  assign ram_we  = fin_go && do_write_q;

  bsa_ram #(
    .DEPTH (bsa_pkg::NUM_BLOCKS),
    .WIDTH (bsa_pkg::SLOTS_PER_BLOCK),
    .AW    (bsa_pkg::BLK_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (k_q),
    .wr_data (mask_q),
    .rd_en   (ram_re),
    .rd_addr (k_q),
    .rd_data (ram_rdata)
  );

  // first byte group holding a clear bit
  always_comb begin
    grp_pick = '0;
    for (int g = bsa_pkg::NUM_GRPS - 1; g >= 0; g--) begin
      if (gz_q[g]) begin
        grp_pick = bsa_pkg::GRP_W'(g);
      end
    end
  end

  // first clear bit inside the chosen group
  always_comb begin
    grp_byte = mask_q[grp_q * bsa_pkg::GRP_SIZE +: bsa_pkg::GRP_SIZE];
    bit_pick = '0;
    for (int j = bsa_pkg::GRP_SIZE - 1; j >= 0; j--) begin
      if (!grp_byte[j]) begin
        bit_pick = bsa_pkg::GRP_W'(j);
      end
    end
  end

  assign slot = {k_q, bit_q};

  // count after this request
  always_comb begin
    cnt_new = cnt;
    if (do_write_q) begin
      if (inc_q) begin
        cnt_new = cnt + 1'b1;
      end else if (cnt != '0) begin
        cnt_new = cnt - 1'b1;
      end
    end
  end

  // config write with clamping to the legal element sizes
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bsa_pkg::REG_ELEMENT_SIZE);
  always_comb begin
    cfg_val = pwdata[bsa_pkg::ESZ_W-1:0];
    if (cfg_val == '0) begin
      cfg_val = bsa_pkg::ESZ_MIN;
    end else if (cfg_val > bsa_pkg::ESZ_MAX) begin
      cfg_val = bsa_pkg::ESZ_MAX;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bsa_pkg::REG_ELEMENT_SIZE) ? bsa_pkg::APB_DW'(esz) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      esz <= bsa_pkg::ESZ_RESET;
    end else if (cfg_wr) begin
      esz <= cfg_val;
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      blk_valid <= '0;
      cnt       <= '0;
    end else begin
      // a new result loads only once the held one has gone
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_q     <= in_func;
            k_q        <= '0;
            do_write_q <= 1'b0;
            inc_q      <= 1'b0;
            res_off_q  <= '0;
            if (in_func == bsa_pkg::FN_ALLOC) begin
              state <= S_RD;
            end else if (out_of_range) begin
              st_q  <= bsa_pkg::ST_RANGE;
              state <= S_FIN;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_RD: begin
          rd_valid_q <= blk_valid[k_q];
          state      <= S_CHK;
        end
        S_CHK: begin
          if (func_q == bsa_pkg::FN_ALLOC) begin
            if (&mask_rd) begin
              // block full, move on or give up
              if (k_q == bsa_pkg::BLK_W'(bsa_pkg::NUM_BLOCKS - 1)) begin
                st_q  <= bsa_pkg::ST_FULL;
                state <= S_FIN;
              end else begin
                k_q   <= k_q + 1'b1;
                state <= S_RD;
              end
            end else begin
              mask_q <= mask_rd;
              for (int g = 0; g < bsa_pkg::NUM_GRPS; g++) begin
                gz_q[g] <= ~&mask_rd[g * bsa_pkg::GRP_SIZE +: bsa_pkg::GRP_SIZE];
              end
              state <= S_GRP;
            end
          end else begin
            if (!mask_rd[bit_q]) begin
              st_q  <= bsa_pkg::ST_UNUSED;
              state <= S_FIN;
            end else begin
              mask_q     <= mask_rd & ~(bsa_pkg::SLOTS_PER_BLOCK'(1) << bit_q);
              do_write_q <= 1'b1;
              inc_q      <= 1'b0;
              st_q       <= bsa_pkg::ST_OK;
              state      <= S_FIN;
            end
          end
        end
        S_GRP: begin
          grp_q <= grp_pick;
          state <= S_BIT;
        end
        S_BIT: begin
          bit_q <= {grp_q, bit_pick};
          state <= S_MUL;
        end
        S_MUL: begin
          prod_q <= bsa_pkg::PROD_W'(slot) * bsa_pkg::PROD_W'(esz);
          state  <= S_ALLOC;
        end
        S_ALLOC: begin
          // lowest free slot past the offset range means nothing higher fits either
          if (bsa_pkg::CMP_W'(prod_q) <= bsa_pkg::CMP_W'(bsa_pkg::OFFSET_MAX)) begin
            st_q       <= bsa_pkg::ST_OK;
            res_off_q  <= prod_q[bsa_pkg::OFF_W-1:0];
            mask_q     <= mask_q | (bsa_pkg::SLOTS_PER_BLOCK'(1) << bit_q);
            do_write_q <= 1'b1;
            inc_q      <= 1'b1;
          end else begin
            st_q <= bsa_pkg::ST_FULL;
          end
          state <= S_FIN;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.rem != '0) begin
              st_q  <= bsa_pkg::ST_ALIGN;
              state <= S_FIN;
            end else begin
              // range check already keeps the slot inside the pool
              k_q   <= div_rsp.quot[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
              bit_q <= div_rsp.quot[bsa_pkg::BIT_W-1:0];
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_st   <= st_q;
            out_off  <= res_off_q;
            out_used <= (cnt_new > bsa_pkg::CNT_W'(bsa_pkg::USED_SAT)) ?
                        bsa_pkg::USED_W'(bsa_pkg::USED_SAT) : bsa_pkg::USED_W'(cnt_new);
            cnt      <= cnt_new;
            if (do_write_q) begin
              blk_valid[k_q] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tuser = out_st;
  assign m_tdata = {{bsa_pkg::M_PAD_W{1'b0}}, out_used, out_off};

endmodule

// File: design/bsa_ram.sv
// generic single-write, single-read synchronous ram, registered read data
module bsa_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 64,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/bsa_div.sv
// restoring divider, one quotient bit per cycle, splits a byte offset into slot and remainder
module bsa_div (
  input  logic               clk,
  input  logic               rst,
  input  bsa_pkg::div_req_t  req,
  output bsa_pkg::div_rsp_t  rsp
);

  logic                           busy;
  logic                           done;
  logic [bsa_pkg::DIV_CNT_W-1:0]  cnt;
  logic [bsa_pkg::OFF_W-1:0]      quo;
  logic [bsa_pkg::ESZ_W-1:0]      rem;
  logic [bsa_pkg::ESZ_W-1:0]      dsr;
  logic [bsa_pkg::ESZ_W:0]        trial;
  logic [bsa_pkg::ESZ_W:0]        diff;
  logic                           take;

  always_comb begin
    trial = {rem, quo[bsa_pkg::OFF_W-1]};
    diff  = trial - {1'b0, dsr};
    take  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= bsa_pkg::DIV_CNT_W'(bsa_pkg::OFF_W);
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= take ? diff[bsa_pkg::ESZ_W-1:0] : trial[bsa_pkg::ESZ_W-1:0];
        quo <= {quo[bsa_pkg::OFF_W-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == bsa_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

// File: design/bsa_checker.sv
// port-level checks for the bitmap slot allocator, bound to the top level
module bsa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bsa_pkg::M_TDATA_W-1:0]   m_tdata,
  input logic [bsa_pkg::ST_W-1:0]        m_tuser
);

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= bsa_pkg::ST_UNUSED))
    else $error("bsa: undefined status code");

  // a failed request carries a zero offset
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != bsa_pkg::ST_OK)) |-> (m_tdata[bsa_pkg::OFF_W-1:0] == '0))
    else $error("bsa: nonzero offset on a failed request");

  // used count never exceeds the pool
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[bsa_pkg::OFF_W +: bsa_pkg::USED_W] <= bsa_pkg::NUM_SLOTS))
    else $error("bsa: used count beyond pool size");

  // no request taken while one is being worked: next transfer waits for a result
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("bsa: request accepted while busy");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("bsa: stalled result changed");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (.*);

// File: bench/bitmap_slot_allocator_unit_test.sv
// self-checking testbench for the bitmap slot allocator: stream driver, result monitor and apb setup
`timescale 1ns / 1ps

module bitmap_slot_allocator_unit_test;

  // no-transfer cycles before the run is declared hung; the longest legal quiet stretch comes
  // from the backlog hold below
  localparam int WATCHDOG_LIMIT = 5000;
  // receiver backlog test: stop draining after this many request transfers, for this long
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 400;
  // settling time after the last result, well above the worst request latency
  localparam int TAIL_CYCLES    = 60;
  localparam logic [bsa_pkg::APB_AW-1:0] ESZ_ADDR =
    bsa_pkg::APB_AW'(4 * int'(bsa_pkg::REG_ELEMENT_SIZE));

  typedef struct packed {
    logic                      fn;
    logic [bsa_pkg::OFF_W-1:0] off;
  } slot_req_t;

  typedef struct packed {
    bsa_pkg::status_t           status;
    logic [bsa_pkg::OFF_W-1:0]  slot_off;
    logic [bsa_pkg::USED_W-1:0] used;
  } slot_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [bsa_pkg::S_TDATA_W-1:0] s_tdata = '0;   // [19:0] byte_offset, [23:20] zero
  logic                          s_tuser = 1'b0; // [0] func
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [bsa_pkg::M_TDATA_W-1:0] m_tdata;  // [19:0] slot_offset, [28:20] used_count, [31:29] zero
  logic [bsa_pkg::ST_W-1:0]      m_tuser;  // [2:0] status
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [bsa_pkg::APB_AW-1:0]    paddr = '0;
  logic [bsa_pkg::APB_DW-1:0]    pwdata = '0;
  logic [bsa_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  bitmap_slot_allocator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // allocator model: masks, exact used count and the element size in force
  logic [bsa_pkg::SLOTS_PER_BLOCK-1:0] pool_mask [bsa_pkg::NUM_BLOCKS];
  int unsigned                         pool_used = 0;
  int unsigned                         cur_esz = 16;

  // stimulus side shadow of which slots are taken, used only to aim frees at live slots
  logic [bsa_pkg::NUM_SLOTS-1:0] gen_used = '0;

  slot_req_t    queued_requests[$];
  slot_result_t awaited_results[$];
  int           requests_queued = 0;
  int           results_done = 0;
  int           accepted_requests = 0;
  int           mismatches = 0;

  // handshake bookkeeping between the posedge monitor and the negedge drivers
  logic         s_took = 1'b0;
  int           tx_gap = 0;
  logic         tx_quiet = 1'b0;
  slot_req_t    tx_req;
  int           rx_stall = 0;
  logic         rx_quiet = 1'b0;
  int           backlog_hold = 0;
  logic         backlog_done = 1'b0;

  initial begin
    for (int k = 0; k < bsa_pkg::NUM_BLOCKS; k++) pool_mask[k] = '0;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t ns: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(15, 60);
  endfunction

  // one request through the allocator model, returning the result it must produce
  function automatic slot_result_t serve_request(logic fn, logic [bsa_pkg::OFF_W-1:0] off);
    slot_result_t res;
    int unsigned  slot;
    int unsigned  byte_off;
    int unsigned  blk;
    int unsigned  bit_pos;
    logic         found;
    res.status   = bsa_pkg::ST_OK;
    res.slot_off = '0;
    found        = 1'b0;
    if (fn == bsa_pkg::FN_ALLOC) begin
      res.status = bsa_pkg::ST_FULL;
      for (int k = 0; k < bsa_pkg::NUM_BLOCKS; k++) begin
        if (!found && pool_mask[k] != '1) begin
          found   = 1'b1;
          bit_pos = 0;
          while (bit_pos < bsa_pkg::SLOTS_PER_BLOCK - 1 && pool_mask[k][bit_pos]) bit_pos++;
          slot     = k * bsa_pkg::SLOTS_PER_BLOCK + bit_pos;
          byte_off = slot * cur_esz;
          // lowest free slot whose offset does not fit in the field: pool full
          if (byte_off <= bsa_pkg::OFFSET_MAX) begin
            pool_mask[k][bit_pos] = 1'b1;
            pool_used++;
            res.status   = bsa_pkg::ST_OK;
            res.slot_off = bsa_pkg::OFF_W'(byte_off);
          end
        end
      end
    end else begin
      // range first, then alignment, then whether the slot is live
      if (off >= bsa_pkg::NUM_SLOTS * cur_esz) begin
        res.status = bsa_pkg::ST_RANGE;
      end else if (off % cur_esz != 0) begin
        res.status = bsa_pkg::ST_ALIGN;
      end else begin
        slot    = off / cur_esz;
        blk     = slot / bsa_pkg::SLOTS_PER_BLOCK;
        bit_pos = slot % bsa_pkg::SLOTS_PER_BLOCK;
        if (!pool_mask[blk][bit_pos]) begin
          res.status = bsa_pkg::ST_UNUSED;
        end else begin
          pool_mask[blk][bit_pos] = 1'b0;
          if (pool_used > 0) pool_used--;
        end
      end
    end
    res.used = (pool_used > bsa_pkg::USED_SAT) ? bsa_pkg::USED_W'(bsa_pkg::USED_SAT) :
                                                bsa_pkg::USED_W'(pool_used);
    return res;
  endfunction

  // adds a request to the stream and keeps the stimulus shadow in step
  function automatic void queue_request(logic fn, int unsigned off);
    slot_req_t req;
    int        k;
    if (fn == bsa_pkg::FN_ALLOC) begin
      k = 0;
      while (k < bsa_pkg::NUM_SLOTS && gen_used[k]) k++;
      if (k < bsa_pkg::NUM_SLOTS && k * cur_esz <= bsa_pkg::OFFSET_MAX) gen_used[k] = 1'b1;
    end else if (off < bsa_pkg::NUM_SLOTS * cur_esz && off % cur_esz == 0) begin
      gen_used[off / cur_esz] = 1'b0;
    end
    req.fn  = fn;
    req.off = bsa_pkg::OFF_W'(off);
    queued_requests = {queued_requests, req};
    requests_queued++;
  endfunction

  // random request: allocates with random ignored offsets, frees mostly aimed at live slots,
  // the rest stale, misaligned, at the range boundary or plain noise
  function automatic void queue_random(int alloc_pct);
    int          r;
    int unsigned slot;
    int unsigned off;
    int unsigned limit;
    limit = bsa_pkg::NUM_SLOTS * cur_esz;
    if ($urandom_range(0, 99) < alloc_pct) begin
      queue_request(bsa_pkg::FN_ALLOC, $urandom_range(0, bsa_pkg::OFFSET_MAX));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      slot = $urandom_range(0, bsa_pkg::NUM_SLOTS - 1);
      for (int n = 0; n < bsa_pkg::NUM_SLOTS && !gen_used[slot]; n++) begin
        slot = (slot + 1) % bsa_pkg::NUM_SLOTS;
      end
      off = slot * cur_esz;
    end else if (r < 77) begin
      off = $urandom_range(0, bsa_pkg::NUM_SLOTS - 1) * cur_esz;
    end else if (r < 88 && cur_esz > 1) begin
      off = $urandom_range(0, bsa_pkg::NUM_SLOTS - 1) * cur_esz + $urandom_range(1, cur_esz - 1);
    end else if (r < 93 && limit <= bsa_pkg::OFFSET_MAX) begin
      off = $urandom_range(0, 1) ? limit : limit - 1;
    end else begin
      off = $urandom_range(0, bsa_pkg::OFFSET_MAX);
    end
    queue_request(bsa_pkg::FN_FREE, off);
  endfunction

  // apb read of element_size, checked against the model
  task automatic check_element_size();
    logic [bsa_pkg::APB_DW-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ESZ_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got != cur_esz) report_mismatch("element_size read", got, cur_esz);
  endtask

  // apb write; the model stores the clamped value just as the register does
  task automatic write_element_size(logic [bsa_pkg::APB_DW-1:0] value);
    int unsigned v;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ESZ_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = value & 32'h1FFF;
    if (v == 0) v = 1;
    if (v > bsa_pkg::ESZ_MAX) v = bsa_pkg::ESZ_MAX;
    cur_esz = v;
    check_element_size();
  endtask

  // sender pause: nothing more goes out until every result is back
  task automatic wait_drained();
    do @(negedge clk); while (results_done != requests_queued);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [bsa_pkg::APB_DW-1:0] esz_value, int items, int alloc_pct);
    write_element_size(esz_value);
    for (int i = 0; i < items; i++) queue_random(alloc_pct);
    wait_drained();
  endtask

  // request driver: holds an offered transfer until taken, then maybe idles
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_took) begin
      // still waiting for s_tready
    end else if (tx_gap > 0) begin
      s_tvalid <= 1'b0;
      tx_gap   <= tx_gap - 1;
    end else if (queued_requests.size() > 0) begin
      tx_req   = queued_requests.pop_front();
      s_tvalid <= 1'b1;
      s_tuser  <= tx_req.fn;
      s_tdata  <= bsa_pkg::S_TDATA_W'(tx_req.off);
      tx_gap   <= (!tx_quiet && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
      if ($urandom_range(0, 99) == 0) tx_quiet <= !tx_quiet;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result receiver: random stalls, quiet stretches, and one long backlog hold
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (backlog_hold > 0) begin
      m_tready     <= 1'b0;
      backlog_hold <= backlog_hold - 1;
    end else if (!backlog_done && accepted_requests >= HOLD_AT) begin
      // sender keeps offering while the block backs up and drops s_tready
      m_tready     <= 1'b0;
      backlog_hold <= HOLD_CYCLES;
      backlog_done <= 1'b1;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      m_tready <= 1'b1;
      if (!rx_quiet && $urandom_range(0, 99) < 30) rx_stall <= pick_gap();
      if ($urandom_range(0, 199) == 0) rx_quiet <= !rx_quiet;
    end
  end

  // monitor: check the result transfer against the oldest expectation, then predict for
  // the request transfer of the same edge
  always @(posedge clk) begin
    slot_result_t want;
    slot_result_t pred;
    s_took <= s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_done <= results_done + 1;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status", m_tuser, 0);
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser != want.status) report_mismatch("status", m_tuser, want.status);
          if (m_tdata[bsa_pkg::OFF_W-1:0] != want.slot_off) begin
            report_mismatch("slot_offset", m_tdata[bsa_pkg::OFF_W-1:0], want.slot_off);
          end
          if (m_tdata[bsa_pkg::OFF_W +: bsa_pkg::USED_W] != want.used) begin
            report_mismatch("used_count", m_tdata[bsa_pkg::OFF_W +: bsa_pkg::USED_W], want.used);
          end
          if (m_tdata[bsa_pkg::M_TDATA_W-1 -: bsa_pkg::M_PAD_W] != '0) begin
            report_mismatch("tdata padding", m_tdata[bsa_pkg::M_TDATA_W-1 -: bsa_pkg::M_PAD_W], 0);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pred = serve_request(s_tuser, s_tdata[bsa_pkg::OFF_W-1:0]);
        awaited_results = {awaited_results, pred};
        accepted_requests <= accepted_requests + 1;
      end
    end
  end

  // hang detector: any stretch with no transfer on either stream
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("bitmap_slot_allocator_unit regression: fail");
    $finish;
  end

  initial begin : sequencer
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value, then a write with junk above the 13-bit field
    check_element_size();
    write_element_size(32'hFFFF_E010);

    // directed checks at 16 bytes per slot
    queue_request(bsa_pkg::FN_FREE, 0);                     // free on an empty pool
    queue_request(bsa_pkg::FN_ALLOC, bsa_pkg::OFFSET_MAX);  // offset ignored on allocate
    queue_request(bsa_pkg::FN_ALLOC, 0);
    queue_request(bsa_pkg::FN_ALLOC, 0);
    queue_request(bsa_pkg::FN_FREE, 16);
    queue_request(bsa_pkg::FN_FREE, 16);                    // double free, slot not in use
    queue_request(bsa_pkg::FN_ALLOC, 0);                    // lowest hole gets reused
    queue_request(bsa_pkg::FN_FREE, 17);                    // misaligned
    queue_request(bsa_pkg::FN_FREE, 4096);                  // exactly at the range limit
    queue_request(bsa_pkg::FN_FREE, 4095);                  // in range but misaligned
    queue_request(bsa_pkg::FN_FREE, 4080);                  // last slot, never allocated
    queue_request(bsa_pkg::FN_FREE, bsa_pkg::OFFSET_MAX);   // out of range and misaligned
    queue_request(bsa_pkg::FN_FREE, 32);
    queue_request(bsa_pkg::FN_FREE, 0);
    queue_request(bsa_pkg::FN_FREE, 16);
    queue_request(bsa_pkg::FN_ALLOC, 0);
    wait_drained();

    // random phases over several element sizes; the masks carry across size changes
    run_phase(32'd0, 300, 95);            // zero clamps to one; fill until pool full
    run_phase(32'd4096, 150, 25);         // largest size, draining
    run_phase(32'd8191, 150, 50);         // above the maximum, clamps to 4096
    run_phase(32'd3, 200, 60);            // backlog hold lands here
    run_phase(32'h0000_2007, 150, 25);    // bit 13 dropped, size 7
    run_phase($urandom_range(1, 4096), 150, 50);
    run_phase(32'd1, 150, 95);
    run_phase(32'd5000, 130, 20);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("bitmap_slot_allocator_unit regression: pass");
    end else begin
      $display("bitmap_slot_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: bitmap_slot_allocator_unit.f
design/bsa_pkg.sv
design/bsa_ram.sv
design/bsa_div.sv
design/bitmap_slot_allocator_unit.sv
design/bsa_checker.sv
bench/bitmap_slot_allocator_unit_test.sv
